### rtl/ovr_pkg.sv
// ---------------------------------------------------------------------------
// Overwrite-oldest sample ring: shared package
// Beat types, command codes, state codes and sizing constants for the ring.
// ---------------------------------------------------------------------------
`default_nettype none

package ovr_pkg;

    // Sizing defaults for the top-level parameters.
    localparam int unsigned MAX_ENTRIES_DEFAULT = 48000;
    localparam int unsigned MAX_BURST_DEFAULT   = 32;

    // Buffer length in milliseconds and its clamp limits.
    localparam int unsigned MS_WIDTH = 10;
    localparam int unsigned MS_MIN   = 10;
    localparam int unsigned MS_MAX   = 500;
    localparam int unsigned MS_RESET = 100;

    // 48000 samples per second, two channels.
    localparam int unsigned SAMPLE_RATE    = 48000;
    localparam int unsigned SAMPLES_PER_MS = (SAMPLE_RATE * 2) / 1000;

    localparam int unsigned SAMPLE_WIDTH = 16;
    localparam int unsigned FILL_WIDTH   = 16;
    localparam int unsigned REQ_WIDTH    = 6;
    localparam int unsigned RAW_DEPTH_WIDTH = 16;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    typedef struct packed {
        logic [1:0]                     command;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic [REQ_WIDTH-1:0]           read_request;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           sample_valid;
        logic                           last_of_run;
        logic [FILL_WIDTH-1:0]          fill_level;
        logic                           dropped_oldest;
    } result_beat_t;

    // Enables from the controller to the sample memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // Unsaturated depth for a requested length: clamp, then times 96.
    function automatic logic [RAW_DEPTH_WIDTH-1:0] raw_depth(input logic [MS_WIDTH-1:0] ms);
        logic [MS_WIDTH-1:0]        ms_c;
        logic [RAW_DEPTH_WIDTH-1:0] ms_w;
        ms_c = ms;
        if (ms_c < MS_WIDTH'(MS_MIN)) begin
            ms_c = MS_WIDTH'(MS_MIN);
        end
        if (ms_c > MS_WIDTH'(MS_MAX)) begin
            ms_c = MS_WIDTH'(MS_MAX);
        end
        ms_w = RAW_DEPTH_WIDTH'(ms_c);
        return (ms_w << 6) + (ms_w << 5);
    endfunction

endpackage

`default_nettype wire

### rtl/ovr_mem.sv
// ---------------------------------------------------------------------------
// Overwrite-oldest sample ring: sample memory
// Single-clock memory, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ovr_mem #(
    parameter int unsigned MAX_ENTRIES = ovr_pkg::MAX_ENTRIES_DEFAULT,
    parameter int unsigned AW          = $clog2(MAX_ENTRIES)
) (
    input  wire logic                                     clk,
    input  wire ovr_pkg::mem_ctl_t                        ctl,
    input  wire logic [AW-1:0]                            wr_addr,
    input  wire logic signed [ovr_pkg::SAMPLE_WIDTH-1:0]  wr_data,
    input  wire logic [AW-1:0]                            rd_addr,
    output logic signed [ovr_pkg::SAMPLE_WIDTH-1:0]       rd_data
);
    import ovr_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] store [MAX_ENTRIES];
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/ovr_ctrl.sv
// ---------------------------------------------------------------------------
// Overwrite-oldest sample ring: controller
// Pointers, fill count, depth register, burst sequencer and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ovr_ctrl #(
    parameter int unsigned MAX_ENTRIES = ovr_pkg::MAX_ENTRIES_DEFAULT,
    parameter int unsigned MAX_BURST   = ovr_pkg::MAX_BURST_DEFAULT,
    parameter int unsigned AW          = $clog2(MAX_ENTRIES)
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     start,
    output logic                                          busy,
    input  wire ovr_pkg::cmd_beat_t                       cmd,
    output logic                                          result_strobe,
    output ovr_pkg::result_beat_t                         result,
    input  wire logic                                     cfg_write_en,
    input  wire logic [ovr_pkg::MS_WIDTH-1:0]             cfg_write_data,
    output ovr_pkg::mem_ctl_t                             mem_ctl,
    output logic [AW-1:0]                                 mem_wr_addr,
    output logic signed [ovr_pkg::SAMPLE_WIDTH-1:0]       mem_wr_data,
    output logic [AW-1:0]                                 mem_rd_addr,
    input  wire logic signed [ovr_pkg::SAMPLE_WIDTH-1:0]  mem_rd_data
);
    import ovr_pkg::*;

    localparam int unsigned DW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CW = $clog2(MAX_BURST + 1);
    localparam int unsigned XW = 17;
    localparam int unsigned RST_RAW   = MS_RESET * SAMPLES_PER_MS;
    localparam int unsigned DEPTH_RST = (RST_RAW > MAX_ENTRIES) ? MAX_ENTRIES : RST_RAW;

    state_t                 state_reg, state_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic [AW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          cnt_reg, cnt_next;

    logic                   res_valid_reg, res_valid_next;
    logic                   res_sample_reg, res_sample_next;
    logic                   res_last_reg, res_last_next;
    logic [AW-1:0]          res_fill_reg, res_fill_next;
    logic                   res_drop_reg, res_drop_next;

    logic                   accept;
    logic [RAW_DEPTH_WIDTH-1:0] raw;
    logic [CW-1:0]          burst_sat;
    logic [CW-1:0]          burst_n;
    logic                   ring_full;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                              input logic [DW-1:0] d);
        logic [AW:0] inc;
        inc = {1'b0, p} + 1'b1;
        return (inc == (AW+1)'(d)) ? '0 : inc[AW-1:0];
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_READ);
    assign raw    = raw_depth(cfg_write_data);

    // Requested burst, limited by the burst size and then by the fill level.
    always_comb
    begin
        if ({1'b0, cmd.read_request} > (REQ_WIDTH+1)'(MAX_BURST))
        begin
            burst_sat = CW'(MAX_BURST);
        end
        else
        begin
            burst_sat = CW'(cmd.read_request);
        end
        if (XW'(fill_reg) < XW'(burst_sat))
        begin
            burst_n = CW'(fill_reg);
        end
        else
        begin
            burst_n = burst_sat;
        end
    end

    // A write drops the oldest sample when the ring already holds depth-1.
    assign ring_full = ((XW'(fill_reg) + 1'b1) == XW'(depth_reg));

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        res_valid_next  = 1'b0;
        res_sample_next = 1'b0;
        res_last_next   = 1'b1;
        res_fill_next   = fill_reg;
        res_drop_next   = 1'b0;
        mem_ctl.wr_en   = 1'b0;
        mem_ctl.rd_en   = 1'b0;

        if (cfg_write_en)
        begin
            if (XW'(raw) > XW'(MAX_ENTRIES))
            begin
                depth_next = DW'(MAX_ENTRIES);
            end
            else
            begin
                depth_next = DW'(raw);
            end
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
        end
        else if (state_reg == ST_READ)
        begin
            mem_ctl.rd_en   = 1'b1;
            rd_ptr_next     = advance(rd_ptr_reg, depth_reg);
            fill_next       = fill_reg - 1'b1;
            cnt_next        = cnt_reg - 1'b1;
            res_valid_next  = 1'b1;
            res_sample_next = 1'b1;
            res_last_next   = (cnt_reg == CW'(1));
            res_fill_next   = fill_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                state_next = ST_IDLE;
            end
        end
        else if (accept)
        begin
            unique case (cmd_t'(cmd.command))
                CMD_WRITE:
                begin
                    mem_ctl.wr_en  = 1'b1;
                    wr_ptr_next    = advance(wr_ptr_reg, depth_reg);
                    res_valid_next = 1'b1;
                    if (ring_full)
                    begin
                        rd_ptr_next   = advance(rd_ptr_reg, depth_reg);
                        res_drop_next = 1'b1;
                    end
                    else
                    begin
                        fill_next     = fill_reg + 1'b1;
                        res_fill_next = fill_reg + 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (burst_n == '0)
                    begin
                        res_valid_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next   = burst_n;
                        state_next = ST_READ;
                    end
                end
                CMD_QUERY:
                begin
                    res_valid_next = 1'b1;
                end
                CMD_CLEAR:
                begin
                    wr_ptr_next    = '0;
                    rd_ptr_next    = '0;
                    fill_next      = '0;
                    res_fill_next  = '0;
                    res_valid_next = 1'b1;
                end
                default:
                begin
                    res_valid_next = 1'b1;
                end
            endcase
        end
    end

    assign mem_wr_addr = wr_ptr_reg;
    assign mem_wr_data = cmd.sample_in;
    assign mem_rd_addr = rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= DW'(DEPTH_RST);
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_sample_reg <= res_sample_next;
        res_last_reg   <= res_last_next;
        res_fill_reg   <= res_fill_next;
        res_drop_reg   <= res_drop_next;
    end

    // Read data arrives from the memory in the same cycle as the strobe.
    assign result_strobe         = res_valid_reg;
    assign result.sample_out     = res_sample_reg ? mem_rd_data : '0;
    assign result.sample_valid   = res_sample_reg;
    assign result.last_of_run    = res_last_reg;
    assign result.fill_level     = FILL_WIDTH'(res_fill_reg);
    assign result.dropped_oldest = res_drop_reg;

endmodule

`default_nettype wire

### rtl/overwrite_oldest_sample_ring_top.sv
// ---------------------------------------------------------------------------
// Overwrite-oldest sample ring
// Ring buffer of signed 16-bit audio samples that overwrites its oldest
// sample when full, with burst reads, fill query and clear.
// ---------------------------------------------------------------------------
// Using the block: a command beat is taken on a rising edge where start is
// high, busy is low and cfg_write_en is low. Write, query and clear
// commands each give a single result on result with result_strobe high in
// the following cycle; busy stays low, so such commands may be issued every
// cycle. A read of N samples (N up to MAX_BURST and no more than the fill
// level) raises busy while the sequencer reads one sample per cycle from
// the sample memory; the results follow one per cycle, each in the cycle
// after its memory read, so the first arrives once the read state and then
// the memory read data have been registered, and the last one carries
// last_of_run. The pace of a burst is set by the single read port of the
// sample memory, and the block takes no new command while a burst is read.
// A read that finds nothing returns one result with sample_valid low.
// Results are strobed for exactly one cycle and cannot be held off, so the
// receiver must take every strobed beat. The depth is 96 samples per
// millisecond of the clamped buffer length (10 to 500 ms, reset 100 ms),
// limited to MAX_ENTRIES; at most depth minus one samples are held. Writing
// the length register empties the ring and should only be done while the
// block is idle. The memory needs no clearing pass: only samples written
// since the ring was last emptied are ever read back.
// ---------------------------------------------------------------------------
`default_nettype none

module overwrite_oldest_sample_ring_top #(
    parameter int unsigned MAX_ENTRIES = ovr_pkg::MAX_ENTRIES_DEFAULT,
    parameter int unsigned MAX_BURST   = ovr_pkg::MAX_BURST_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire ovr_pkg::cmd_beat_t            cmd,
    output logic                               result_strobe,
    output ovr_pkg::result_beat_t              result,
    input  wire logic                          cfg_write_en,
    input  wire logic [ovr_pkg::MS_WIDTH-1:0]  cfg_write_data
);
    import ovr_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ENTRIES);

    mem_ctl_t                       mem_ctl;
    logic [AW-1:0]                  mem_wr_addr;
    logic signed [SAMPLE_WIDTH-1:0] mem_wr_data;
    logic [AW-1:0]                  mem_rd_addr;
    logic signed [SAMPLE_WIDTH-1:0] mem_rd_data;

    // Pointer and burst control; owns every register except the sample store and its read data register.
    ovr_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_BURST   (MAX_BURST),
        .AW          (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .result_strobe  (result_strobe),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mem_ctl        (mem_ctl),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

    // Sample storage with a registered read.
    ovr_mem #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire
